FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When a holds, b must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// When a holds, b must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

FILE: src/ctbd_pkg.sv
// ----------------------------------------------------------------------------
// ctbd_pkg
// Types, character codes and decode functions of the coded text byte decoder.
// ----------------------------------------------------------------------------
package ctbd_pkg;

    localparam int MAX_RUN = 5;
    localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);
    localparam int RUN_IDX_W = $clog2(MAX_RUN);

    localparam logic [7:0] END_BYTE  = 8'd31;
    localparam logic [7:0] BELL_CODE = 8'd7;
    localparam logic [7:0] ARG1_LO   = 8'd16;
    localparam logic [7:0] ARG1_HI   = 8'd21;
    localparam logic [7:0] ARG2_A    = 8'd22;
    localparam logic [7:0] ARG2_B    = 8'd23;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_GRAVE  = 8'd96;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DEL    = 8'd127;

    // One decoded item: the characters it emits, first at index 0.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] chars;
        logic [RUN_CNT_W-1:0]    count;
        logic                    eot;
    } run_t;

    // Decoder status seen by the top level.
    typedef struct packed {
        logic       stage_valid;
        logic [1:0] pending;
    } ctbd_status_t;

    // Braced decimal form of a byte, without leading zeros.
    function automatic run_t braced(input logic [7:0] v);
        run_t       r;
        logic [1:0] hund;
        logic [7:0] rem8;
        logic [6:0] rem;
        logic [13:0] prod;
        logic [3:0] tens;
        logic [6:0] ones7;
        logic [7:0] ch_h;
        logic [7:0] ch_t;
        logic [7:0] ch_o;
        hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        rem8 = v - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
        rem = rem8[6:0];
        // Division by ten through the reciprocal 103/1024, exact below 100.
        prod = 14'(rem) * 14'd103;
        tens = prod[13:10];
        ones7 = rem - 7'(tens) * 7'd10;
        ch_h = CH_ZERO + 8'(hund);
        ch_t = CH_ZERO + 8'(tens);
        ch_o = CH_ZERO + 8'(ones7[3:0]);
        r.eot = 1'b0;
        r.chars = '0;
        r.chars[0] = CH_LBRACE;
        if (v >= 8'd100)
        begin
            r.chars[1] = ch_h;
            r.chars[2] = ch_t;
            r.chars[3] = ch_o;
            r.chars[4] = CH_RBRACE;
            r.count = RUN_CNT_W'(5);
        end
        else if (v >= 8'd10)
        begin
            r.chars[1] = ch_t;
            r.chars[2] = ch_o;
            r.chars[3] = CH_RBRACE;
            r.count = RUN_CNT_W'(4);
        end
        else
        begin
            r.chars[1] = ch_o;
            r.chars[2] = CH_RBRACE;
            r.count = RUN_CNT_W'(3);
        end
        return r;
    endfunction

    // A run of a single character.
    function automatic run_t single(input logic [7:0] c);
        run_t r;
        r.chars = '0;
        r.chars[0] = c;
        r.count = RUN_CNT_W'(1);
        r.eot = 1'b0;
        return r;
    endfunction

    // Full decode of one byte given the pending argument count.
    function automatic run_t decode(input logic [7:0] b, input logic [1:0] pending);
        run_t r;
        if (b == END_BYTE)
        begin
            r = single(8'd0);
            r.eot = 1'b1;
        end
        else if (pending != 2'd0)
            r = braced(b);
        else if (b == CH_LBRACE || b == CH_CARET || b == CH_BSLASH)
        begin
            r = single(CH_BSLASH);
            r.chars[1] = b;
            r.count = RUN_CNT_W'(2);
        end
        else if (b == ARG2_A || b == ARG2_B)
            r = single(CH_SPACE);
        else if (b > END_BYTE && b < CH_DEL && b != CH_GRAVE)
            r = single(b);
        else if (b == BELL_CODE)
            r = single(CH_CARET);
        else
            r = braced(b);
        return r;
    endfunction

    // Pending argument count after one byte.
    function automatic logic [1:0] next_pending(input logic [7:0] b, input logic [1:0] pending);
        logic [1:0] p;
        if (b == END_BYTE)
            p = 2'd0;
        else if (pending != 2'd0)
            p = pending - 2'd1;
        else if (b >= ARG1_LO && b <= ARG1_HI)
            p = 2'd1;
        else if (b == ARG2_A || b == ARG2_B)
            p = 2'd2;
        else
            p = 2'd0;
        return p;
    endfunction

endpackage

FILE: src/ctbd_if.sv
// ----------------------------------------------------------------------------
// ctbd_if
// Valid/ready channels for text bytes in and characters out.
// ----------------------------------------------------------------------------
interface ctbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface ctbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       end_of_text;
    logic       last_of_run;

    modport source (output valid, output out_char, output char_valid,
                    output end_of_text, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input char_valid,
                    input end_of_text, input last_of_run, output ready);
endinterface

FILE: src/ctbd_decode.sv
// ----------------------------------------------------------------------------
// ctbd_decode
// Input register: decodes one byte into its character run and tracks
// the pending colour argument count.
// ----------------------------------------------------------------------------
module ctbd_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    ctbd_in_if.sink               in_ch,
    input  logic                  take,
    output ctbd_pkg::run_t        run,
    output ctbd_pkg::ctbd_status_t status
);

    logic           stage_valid_reg;
    logic           stage_valid_next;
    ctbd_pkg::run_t stage_run_reg;
    logic [1:0]     pending_reg;
    logic [1:0]     pending_next;
    logic           in_fire;

    // The stage frees up in the same cycle in which the emitter takes it.
    assign in_ch.ready = !stage_valid_reg || take;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        pending_next     = pending_reg;
        if (in_fire)
        begin
            stage_valid_next = 1'b1;
            pending_next     = ctbd_pkg::next_pending(in_ch.text_byte, pending_reg);
        end
        else if (take)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            pending_reg     <= 2'd0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            pending_reg     <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            stage_run_reg <= ctbd_pkg::decode(in_ch.text_byte, pending_reg);
    end

    assign run                = stage_run_reg;
    assign status.stage_valid = stage_valid_reg;
    assign status.pending     = pending_reg;

endmodule

FILE: src/ctbd_emit.sv
// ----------------------------------------------------------------------------
// ctbd_emit
// Result register: steps through a decoded run, one character per cycle while the output is ready.
// ----------------------------------------------------------------------------
module ctbd_emit (
    input  logic           clk,
    input  logic           rst_n,
    input  ctbd_pkg::run_t run,
    input  logic           run_valid,
    output logic           take,
    ctbd_out_if.source     out_ch
);

    logic                              emit_valid_reg;
    ctbd_pkg::run_t                    emit_run_reg;
    logic [ctbd_pkg::RUN_IDX_W-1:0]    idx_reg;
    logic [ctbd_pkg::RUN_IDX_W-1:0]    idx_next;
    logic                              last;
    logic                              out_fire;
    logic [ctbd_pkg::RUN_CNT_W-1:0]    idx_ext;

    assign idx_ext  = ctbd_pkg::RUN_CNT_W'(idx_reg);
    assign last     = (idx_ext + ctbd_pkg::RUN_CNT_W'(1)) == emit_run_reg.count;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign take     = !emit_valid_reg || (out_fire && last);
    assign idx_next = idx_reg + ctbd_pkg::RUN_IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else if (take)
        begin
            emit_valid_reg <= run_valid;
            idx_reg        <= '0;
        end
        else if (out_fire)
            idx_reg <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && run_valid)
            emit_run_reg <= run;
    end

    assign out_ch.valid       = emit_valid_reg;
    assign out_ch.out_char    = emit_run_reg.chars[idx_reg];
    assign out_ch.char_valid  = !emit_run_reg.eot;
    assign out_ch.end_of_text = emit_run_reg.eot;
    assign out_ch.last_of_run = last;

endmodule

FILE: src/coded_text_byte_decoder_core.sv
// ----------------------------------------------------------------------------
// coded_text_byte_decoder_core
// Turns stored text bytes into escaped source characters, one per item out.
// ----------------------------------------------------------------------------
// Each text byte item yields one to five character items. Byte 31 ends a
// text and gives a single end marker item with no character. While colour
// arguments are pending, bytes are written as a brace, their decimal digits
// and a closing brace; otherwise bytes are escaped, translated, passed through
// or braced. An input byte gives as many output items as it has characters:
// one for plain characters, two for escapes, three to five for braced numbers,
// because the result register hands out one character per cycle while the
// output is ready. A byte is decoded in full in the cycle it is accepted and
// waits in a one-item stage, so the next byte is taken while the previous run
// is still being read out, and runs follow each other without a gap cycle. An
// accepted byte goes through the stage register and then the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module coded_text_byte_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    ctbd_in_if.sink    in_ch,
    ctbd_out_if.source out_ch
);

    ctbd_pkg::run_t         run;
    ctbd_pkg::ctbd_status_t status;
    logic                   take;

    // Decode stage: holds the pending argument count and one decoded run.
    ctbd_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .take   (take),
        .run    (run),
        .status (status)
    );

    // Emit stage: reads the run out one character item per cycle while the output is ready.
    ctbd_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .run       (run),
        .run_valid (status.stage_valid),
        .take      (take),
        .out_ch    (out_ch)
    );

    // The end marker is a run of its own, with no character in it.
    `ASSERT_IMPLIES(a_eot_alone, clk, rst_n, out_ch.valid && out_ch.end_of_text, out_ch.last_of_run && !out_ch.char_valid, "end marker not a lone result")

    // A terminator always clears the pending argument count.
    `ASSERT_NEXT(a_eot_clears, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.text_byte == ctbd_pkg::END_BYTE, status.pending == 2'd0, "terminator left arguments pending")

    // A full stage that the emitter does not take must block the input.
    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, status.stage_valid && !take, !in_ch.ready, "stage overwritten before taken")

    // At most two colour arguments are ever pending.
    `ASSERT_ALWAYS(a_pending_range, clk, rst_n, status.pending != 2'd3, "pending argument count out of range")

endmodule
